/* rtl/clni_pkg.sv */
// ----------------------------------------------------------------------------
// clni_pkg
// Shared types, constants and the microcode table of the 4-bit character LCD
// interface.
// ----------------------------------------------------------------------------
package clni_pkg;

  // Request and result items
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] byte_value;
    logic [1:0] line_number;
    logic [5:0] column;
  } req_t;

  typedef struct packed {
    logic        enable_pin;
    logic        select_pin;
    logic [3:0]  nibble_pins;
    logic [16:0] hold_us;
    logic        last;
  } res_t;

  // Request codes
  localparam logic [1:0] CMD_COMMAND = 2'd0;
  localparam logic [1:0] CMD_DATA    = 2'd1;
  localparam logic [1:0] CMD_CURSOR  = 2'd2;
  localparam logic [1:0] CMD_INIT    = 2'd3;

  // Cursor line codes and addressing
  localparam logic [1:0] LINE_ONE       = 2'd1;
  localparam logic [1:0] LINE_TWO       = 2'd2;
  localparam logic [7:0] LINE2_BASE     = 8'd64;
  localparam logic [7:0] DDRAM_SET      = 8'h80;
  localparam logic [7:0] INIT_FIRST_NIB = 8'h30;

  // Register map (word index taken from paddr[2])
  localparam int unsigned APB_AW    = 3;
  localparam logic        REG_PULSE = 1'b0;
  localparam logic        REG_GAP   = 1'b1;
  localparam logic [7:0]  PULSE_RST = 8'd5;
  localparam logic [15:0] GAP_RST   = 16'd1000;

  // Fixed waits of the init sequence
  localparam logic [16:0] INIT_WAIT_US  = 17'd100000;
  localparam logic [16:0] CLEAR_WAIT_US = 17'd20000;

  // Microcode
  localparam int unsigned PC_W = 4;
  localparam logic [PC_W-1:0] BW_ENTRY   = 4'd0;
  localparam logic [PC_W-1:0] INIT_ENTRY = 4'd6;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_WAIT,
    OP_DRIVE
  } op_e;

  typedef enum logic [2:0] {
    HOLD_GAP,
    HOLD_PULSE,
    HOLD_ZERO,
    HOLD_INIT,
    HOLD_CLEAR
  } hold_e;

  // SEQ: next step; CALL: byte write with return; GOTO: byte write, no return;
  // RET: return to caller, or finish when not called
  typedef enum logic [1:0] {
    FLOW_SEQ,
    FLOW_CALL,
    FLOW_GOTO,
    FLOW_RET
  } flow_e;

  typedef struct packed {
    op_e        op;
    logic       en;
    logic       nib_hi;
    hold_e      hold;
    flow_e      flow;
    logic [7:0] k_byte;
  } uword_t;

  typedef struct packed {
    logic   active;
    logic   last;
    uword_t word;
  } seq_ctrl_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      // shared byte write: gap, high nibble pulse, low nibble pulse, enable up
      4'd0:    w = '{OP_WAIT,  1'b0, 1'b0, HOLD_GAP,   FLOW_SEQ,  8'h00};
      4'd1:    w = '{OP_DRIVE, 1'b1, 1'b1, HOLD_PULSE, FLOW_SEQ,  8'h00};
      4'd2:    w = '{OP_DRIVE, 1'b0, 1'b1, HOLD_PULSE, FLOW_SEQ,  8'h00};
      4'd3:    w = '{OP_DRIVE, 1'b1, 1'b0, HOLD_PULSE, FLOW_SEQ,  8'h00};
      4'd4:    w = '{OP_DRIVE, 1'b0, 1'b0, HOLD_PULSE, FLOW_SEQ,  8'h00};
      4'd5:    w = '{OP_DRIVE, 1'b1, 1'b0, HOLD_ZERO,  FLOW_RET,  8'h00};
      // init: power-up wait, single nibble 3 pulse, then the setup bytes
      4'd6:    w = '{OP_WAIT,  1'b0, 1'b0, HOLD_INIT,  FLOW_SEQ,  8'h00};
      4'd7:    w = '{OP_DRIVE, 1'b1, 1'b1, HOLD_PULSE, FLOW_SEQ,  8'h00};
      4'd8:    w = '{OP_DRIVE, 1'b0, 1'b1, HOLD_PULSE, FLOW_SEQ,  8'h00};
      4'd9:    w = '{OP_DRIVE, 1'b1, 1'b1, HOLD_ZERO,  FLOW_SEQ,  8'h00};
      4'd10:   w = '{OP_NOP,   1'b0, 1'b0, HOLD_ZERO,  FLOW_CALL, 8'h28};
      4'd11:   w = '{OP_NOP,   1'b0, 1'b0, HOLD_ZERO,  FLOW_CALL, 8'h28};
      4'd12:   w = '{OP_NOP,   1'b0, 1'b0, HOLD_ZERO,  FLOW_CALL, 8'h0F};
      4'd13:   w = '{OP_NOP,   1'b0, 1'b0, HOLD_ZERO,  FLOW_CALL, 8'h01};
      4'd14:   w = '{OP_WAIT,  1'b0, 1'b0, HOLD_CLEAR, FLOW_SEQ,  8'h00};
      4'd15:   w = '{OP_NOP,   1'b0, 1'b0, HOLD_ZERO,  FLOW_GOTO, 8'h06};
      default: w = '{OP_NOP,   1'b0, 1'b0, HOLD_ZERO,  FLOW_RET,  8'h00};
    endcase
    return w;
  endfunction

endpackage

/* rtl/clni_seq.sv */
// ----------------------------------------------------------------------------
// clni_seq
// Step counter, one-level return register and microcode table lookup.
// ----------------------------------------------------------------------------
module clni_seq
  import clni_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [PC_W-1:0] start_pc_i,
  input  logic            step_ok_i,
  output seq_ctrl_t       ctrl_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  logic [PC_W-1:0] ret_q, ret_d;
  logic            busy_q, busy_d;
  logic            sub_q, sub_d;
  uword_t          word;

  assign word = ucode(pc_q);

  always_comb begin
    pc_d   = pc_q;
    ret_d  = ret_q;
    busy_d = busy_q;
    sub_d  = sub_q;
    if (start_i) begin
      busy_d = 1'b1;
      pc_d   = start_pc_i;
      sub_d  = 1'b0;
    end else if (busy_q && step_ok_i) begin
      case (word.flow)
        FLOW_SEQ: begin
          pc_d = pc_q + 1'b1;
        end
        FLOW_CALL: begin
          ret_d = pc_q + 1'b1;
          sub_d = 1'b1;
          pc_d  = BW_ENTRY;
        end
        FLOW_GOTO: begin
          sub_d = 1'b0;
          pc_d  = BW_ENTRY;
        end
        FLOW_RET: begin
          if (sub_q) begin
            pc_d  = ret_q;
            sub_d = 1'b0;
          end else begin
            busy_d = 1'b0;
          end
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      busy_q <= 1'b0;
      sub_q  <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
      sub_q  <= sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q <= ret_d;
  end

  assign ctrl_o.active = busy_q;
  assign ctrl_o.last   = busy_q && (word.flow == FLOW_RET) && !sub_q;
  assign ctrl_o.word   = word;

endmodule

/* rtl/char_lcd_nibble_interface.sv */
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface
// Character LCD driver for a 4-bit bus: turns requests into timed pin phases.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------
//  request | in        | in_valid_i/in_ready_o  | in_data_i  (req_t)
//  phase   | out       | out_valid_o/out_ready_i| out_data_o (res_t)
//  config  | in        | APB psel/penable/pready| pwdata / prdata, 32 bits
//
//  One microcode step per cycle while the output register does not stall.
//  Command, data and cursor requests take 6 phases; init takes 35 phases
//  plus 5 call steps, as the step counter walks the microcode table.
//  A new request is taken the cycle after its last phase enters the output
//  register. A stalled output register holds the sequencer on its step.
//  Reset clears the pin levels to zero and loads the register defaults.
// ----------------------------------------------------------------------------
module char_lcd_nibble_interface
  import clni_pkg::*;
#(
  parameter logic [7:0] LINE2_ADDR = LINE2_BASE
)
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  req_t              in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output res_t              out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [7:0]  pulse_q;
  logic [15:0] gap_q;
  logic [7:0]  byte_q, byte_d;
  logic        rs_q;
  logic        en_q, sel_q;
  logic [3:0]  nib_q;
  logic        en_d, sel_d;
  logic [3:0]  nib_d;
  logic        out_valid_q, out_valid_d;
  res_t        out_q, out_d;
  logic        in_xfer, cfg_wr;
  logic        step_ok, out_load, is_drive;
  logic [PC_W-1:0] start_pc;
  logic [7:0]  cursor_addr;
  logic [16:0] hold;
  seq_ctrl_t   ctrl;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign in_xfer = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_q <= PULSE_RST;
      gap_q   <= GAP_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_PULSE) begin
        pulse_q <= pwdata[7:0];
      end else begin
        gap_q <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_PULSE) begin
      prdata = {24'd0, pulse_q};
    end else begin
      prdata = {16'd0, gap_q};
    end
  end

  // Cursor address wraps to 8 bits; lines other than 1 and 2 send command 0
  always_comb begin
    case (in_data_i.line_number)
      LINE_ONE: cursor_addr = DDRAM_SET + {2'b00, in_data_i.column};
      LINE_TWO: cursor_addr = DDRAM_SET + LINE2_ADDR + {2'b00, in_data_i.column};
      default:  cursor_addr = 8'd0;
    endcase
  end

  assign start_pc = (in_data_i.cmd == CMD_INIT) ? INIT_ENTRY : BW_ENTRY;

  clni_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_xfer),
    .start_pc_i (start_pc),
    .step_ok_i  (step_ok),
    .ctrl_o     (ctrl)
  );

  assign in_ready_o = !ctrl.active;
  assign step_ok    = (ctrl.word.op == OP_NOP) || !out_valid_q || out_ready_i;
  assign out_load   = ctrl.active && (ctrl.word.op != OP_NOP) && step_ok;
  assign is_drive   = ctrl.word.op == OP_DRIVE;

  always_comb begin
    case (ctrl.word.hold)
      HOLD_GAP:   hold = {1'b0, gap_q};
      HOLD_PULSE: hold = {9'd0, pulse_q};
      HOLD_INIT:  hold = INIT_WAIT_US;
      HOLD_CLEAR: hold = CLEAR_WAIT_US;
      default:    hold = 17'd0;
    endcase
  end

  // Byte register: loaded by the request, or by a call or goto step of the init program
  always_comb begin
    byte_d = byte_q;
    if (in_xfer) begin
      case (in_data_i.cmd)
        CMD_COMMAND, CMD_DATA: byte_d = in_data_i.byte_value;
        CMD_CURSOR:            byte_d = cursor_addr;
        default:               byte_d = INIT_FIRST_NIB;
      endcase
    end else if (ctrl.active && (ctrl.word.flow == FLOW_CALL ||
                                 ctrl.word.flow == FLOW_GOTO)) begin
      byte_d = ctrl.word.k_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    if (in_xfer) begin
      rs_q <= (in_data_i.cmd == CMD_DATA);
    end
  end

  // Drive steps update the pin levels; wait steps repeat them
  always_comb begin
    en_d  = en_q;
    sel_d = sel_q;
    nib_d = nib_q;
    if (out_load && is_drive) begin
      en_d  = ctrl.word.en;
      sel_d = rs_q;
      nib_d = ctrl.word.nib_hi ? byte_q[7:4] : byte_q[3:0];
    end
  end

  always_comb begin
    out_d.enable_pin  = en_d;
    out_d.select_pin  = sel_d;
    out_d.nibble_pins = nib_d;
    out_d.hold_us     = hold;
    out_d.last        = ctrl.last;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q        <= 1'b0;
      sel_q       <= 1'b0;
      nib_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      en_q        <= en_d;
      sel_q       <= sel_d;
      nib_q       <= nib_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A transfer starts the sequencer, so no second request is taken next cycle
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("request taken while sequencer busy");

  // The final phase of a request frees the request channel
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && ctrl.last |=> in_ready_o)
    else $error("sequencer still busy after final phase");

  // Enable-low drive phases always last one pulse time
  a_low_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && is_drive && !ctrl.word.en |-> hold == {9'd0, pulse_q})
    else $error("enable-low phase with wrong hold");

  // Last flag only on drive phases
  a_last_on_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && ctrl.last |-> is_drive && ctrl.word.en)
    else $error("last flag on a non enable-high phase");

endmodule

/* test/char_lcd_nibble_interface_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface_test
// Self-checking bench for the 4-bit character LCD interface. A clocked driver
// feeds requests from a backlog queue with random gaps. Each accepted request
// is expanded into its expected pin phases by a behavioral sequencer kept
// here. A clocked monitor checks every phase transfer against the oldest
// expected phase while the phase side stalls at random. The hold-time
// registers are rewritten over APB between request batches, including their
// extremes, and read back.
// ----------------------------------------------------------------------------
module char_lcd_nibble_interface_test;
  import clni_pkg::*;

  localparam int unsigned REPORT_LIMIT    = 10;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned CHUNK_ITEMS     = 20;
  localparam int unsigned NUM_SETTINGS    = 5;

  // setup bytes of the power-up sequence
  localparam logic [7:0] FUNC_SET_4BIT = 8'h28;
  localparam logic [7:0] DISPLAY_ON    = 8'h0F;
  localparam logic [7:0] CLEAR_DISPLAY = 8'h01;
  localparam logic [7:0] ENTRY_MODE    = 8'h06;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready_o;
  req_t              in_data   = '0;
  logic              out_valid_o;
  logic              out_ready = 1'b0;
  res_t              out_data_o;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [APB_AW-1:0] paddr     = '0;
  logic [31:0]       pwdata    = '0;
  logic [31:0]       prdata;
  logic              pready;

  char_lcd_nibble_interface u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  req_t        req_backlog[$];
  res_t        phase_expect_q[$];
  int unsigned error_count = 0;
  logic        squeeze_armed = 1'b0;

  // Shadow of the LCD pins and the hold-time registers
  logic        pin_en = 1'b0;
  logic        pin_rs = 1'b0;
  logic [3:0]  pin_nib = 4'h0;
  logic [7:0]  cfg_pulse_us = PULSE_RST;
  logic [15:0] cfg_gap_us = GAP_RST;

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("%t ERROR %s", $realtime, msg);
  endfunction

  function automatic int unsigned pick_idle();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---- phase predictor ----------------------------------------------------

  function automatic void emit_phase(input logic [16:0] hold);
    res_t ph;
    ph.enable_pin  = pin_en;
    ph.select_pin  = pin_rs;
    ph.nibble_pins = pin_nib;
    ph.hold_us     = hold;
    ph.last        = 1'b0;
    phase_expect_q.push_back(ph);
  endfunction

  function automatic void set_pins(input logic en, input logic rs, input logic [3:0] nib,
                                   input logic [16:0] hold);
    pin_en  = en;
    pin_rs  = rs;
    pin_nib = nib;
    emit_phase(hold);
  endfunction

  function automatic void strobe_nibble(input logic rs, input logic [3:0] nib);
    set_pins(1'b1, rs, nib, 17'(cfg_pulse_us));
    set_pins(1'b0, pin_rs, pin_nib, 17'(cfg_pulse_us));
  endfunction

  function automatic void send_byte(input logic rs, input logic [7:0] b);
    emit_phase(17'(cfg_gap_us));
    strobe_nibble(rs, b[7:4]);
    strobe_nibble(rs, b[3:0]);
    set_pins(1'b1, pin_rs, pin_nib, 17'd0);
  endfunction

  function automatic void predict_phases(input req_t r);
    res_t       tail;
    logic [7:0] addr;
    case (r.cmd)
      CMD_COMMAND, CMD_DATA: begin
        send_byte(r.cmd == CMD_DATA, r.byte_value);
      end
      CMD_CURSOR: begin
        if (r.line_number == LINE_ONE) addr = DDRAM_SET + 8'(r.column);
        else if (r.line_number == LINE_TWO) addr = DDRAM_SET + LINE2_BASE + 8'(r.column);
        else addr = 8'h00;
        send_byte(1'b0, addr);
      end
      default: begin
        emit_phase(INIT_WAIT_US);
        strobe_nibble(1'b0, INIT_FIRST_NIB[7:4]);
        set_pins(1'b1, pin_rs, pin_nib, 17'd0);
        send_byte(1'b0, FUNC_SET_4BIT);
        send_byte(1'b0, FUNC_SET_4BIT);
        send_byte(1'b0, DISPLAY_ON);
        send_byte(1'b0, CLEAR_DISPLAY);
        emit_phase(CLEAR_WAIT_US);
        send_byte(1'b0, ENTRY_MODE);
      end
    endcase
    tail = phase_expect_q.pop_back();
    tail.last = 1'b1;
    phase_expect_q.push_back(tail);
  endfunction

  // ---- request driver -----------------------------------------------------

  int unsigned send_idle = 0;
  int unsigned send_calm = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready_o) predict_phases(in_data);
      if (!in_valid || in_ready_o) begin
        if (send_idle != 0) begin
          send_idle--;
          in_valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= req_backlog.pop_front();
          if (send_calm != 0) begin
            send_calm--;
          end else begin
            send_idle = pick_idle();
            if ($urandom_range(0, 15) == 0) send_calm = $urandom_range(15, 40);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---- phase receiver: random stalls plus one long hold-off ---------------

  int unsigned recv_idle = 0;
  int unsigned recv_calm = 0;
  int unsigned squeeze_left = 0;
  logic        squeeze_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (squeeze_armed && !squeeze_done) begin
        squeeze_done = 1'b1;
        squeeze_left = HOLD_OFF_CYCLES;
      end
      if (squeeze_left != 0) begin
        squeeze_left--;
        out_ready <= 1'b0;
      end else if (recv_idle != 0) begin
        recv_idle--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (recv_calm != 0) begin
          recv_calm--;
        end else begin
          recv_idle = pick_idle();
          if ($urandom_range(0, 15) == 0) recv_calm = $urandom_range(20, 60);
        end
      end
    end
  end

  // ---- phase monitor ------------------------------------------------------

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (phase_expect_q.size() == 0) begin
        note_error($sformatf("unexpected phase en=%0b rs=%0b nib=%h hold=%0d last=%0b",
                             out_data_o.enable_pin, out_data_o.select_pin,
                             out_data_o.nibble_pins, out_data_o.hold_us, out_data_o.last));
      end else begin
        want = phase_expect_q.pop_front();
        if (out_data_o.enable_pin !== want.enable_pin ||
            out_data_o.select_pin !== want.select_pin ||
            out_data_o.nibble_pins !== want.nibble_pins ||
            out_data_o.hold_us !== want.hold_us ||
            out_data_o.last !== want.last) begin
          note_error($sformatf({"phase mismatch: exp en=%0b rs=%0b nib=%h hold=%0d last=%0b",
                                " got en=%0b rs=%0b nib=%h hold=%0d last=%0b"},
                               want.enable_pin, want.select_pin, want.nibble_pins,
                               want.hold_us, want.last,
                               out_data_o.enable_pin, out_data_o.select_pin,
                               out_data_o.nibble_pins, out_data_o.hold_us,
                               out_data_o.last));
        end
      end
    end
  end

  // ---- watchdog -----------------------------------------------------------

  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("char_lcd_nibble_interface_test: errors");
        $finish;
      end
    end
  end

  // ---- stimulus -----------------------------------------------------------

  function automatic void queue_req(input logic [1:0] cmd, input logic [7:0] b,
                                    input logic [1:0] line, input logic [5:0] col);
    req_t r;
    r.cmd         = cmd;
    r.byte_value  = b;
    r.line_number = line;
    r.column      = col;
    req_backlog.push_back(r);
  endfunction

  function automatic void queue_random_req();
    req_t        r;
    int unsigned roll;
    roll          = $urandom_range(0, 99);
    r.byte_value  = 8'($urandom);
    r.line_number = 2'($urandom);
    r.column      = 6'($urandom);
    if (roll < 40) r.cmd = CMD_DATA;
    else if (roll < 70) r.cmd = CMD_COMMAND;
    else if (roll < 94) r.cmd = CMD_CURSOR;
    else r.cmd = CMD_INIT;
    // keep most cursor moves on a real line and column
    if (r.cmd == CMD_CURSOR && $urandom_range(0, 9) < 8) begin
      r.line_number = $urandom_range(0, 1) ? LINE_TWO : LINE_ONE;
      r.column      = 6'($urandom_range(0, 39));
    end
    req_backlog.push_back(r);
  endfunction

  // Block is idle once the backlog is sent and every phase has been seen.
  task automatic settle();
    while (req_backlog.size() != 0 || in_valid || phase_expect_q.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apb_write_check(input logic reg_sel, input logic [31:0] value);
    logic [31:0] mask;
    mask = (reg_sel == REG_PULSE) ? 32'h0000_00FF : 32'h0000_FFFF;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({reg_sel, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (reg_sel == REG_PULSE) cfg_pulse_us = value[7:0];
    else cfg_gap_us = value[15:0];
    // read back
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if ((prdata & mask) !== (value & mask))
      note_error($sformatf("register %0d read %h, wrote %h", reg_sel, prdata & mask,
                           value & mask));
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [31:0] pulse_word;
    logic [31:0] gap_word;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed requests under the reset timing
    queue_req(CMD_DATA,    8'h00, 2'd0,     6'd0);
    queue_req(CMD_INIT,    8'hFF, 2'd3,     6'd63);
    queue_req(CMD_COMMAND, 8'hFF, 2'd0,     6'd0);
    queue_req(CMD_DATA,    8'h80, 2'd3,     6'd63);
    queue_req(CMD_DATA,    8'hA5, 2'd0,     6'd0);
    queue_req(CMD_DATA,    8'h5A, 2'd0,     6'd0);
    queue_req(CMD_DATA,    8'hFF, 2'd0,     6'd0);
    queue_req(CMD_COMMAND, 8'h00, 2'd0,     6'd0);
    queue_req(CMD_CURSOR,  8'h00, LINE_ONE, 6'd0);
    queue_req(CMD_CURSOR,  8'hFF, LINE_ONE, 6'd39);
    queue_req(CMD_CURSOR,  8'h00, LINE_ONE, 6'd63);
    queue_req(CMD_CURSOR,  8'h00, LINE_TWO, 6'd0);
    queue_req(CMD_CURSOR,  8'h00, LINE_TWO, 6'd63);
    queue_req(CMD_CURSOR,  8'h3C, 2'd0,     6'd5);
    queue_req(CMD_CURSOR,  8'hC3, 2'd3,     6'd63);
    queue_req(CMD_INIT,    8'h00, 2'd0,     6'd0);
    queue_req(CMD_COMMAND, 8'h01, 2'd2,     6'd42);
    settle();

    for (int unsigned setting = 0; setting < NUM_SETTINGS; setting++) begin
      pulse_word = $urandom;
      gap_word   = $urandom;
      case (setting)
        0: begin
          pulse_word[7:0]  = 8'd1;
          gap_word[15:0]   = 16'd0;
        end
        1: begin
          pulse_word[7:0]  = 8'd255;
          gap_word[15:0]   = 16'd65535;
        end
        2: begin
          // zero pulse: enable phases carry no hold time
          pulse_word[7:0]  = 8'd0;
        end
        default: begin
        end
      endcase
      apb_write_check(REG_PULSE, pulse_word);
      apb_write_check(REG_GAP, gap_word);
      @(negedge clk_i);
      if (setting == 3) squeeze_armed = 1'b1;
      repeat (CHUNK_ITEMS) queue_random_req();
      settle();
    end

    repeat (50) @(negedge clk_i);
    if (error_count == 0 && phase_expect_q.size() == 0) begin
      $display("char_lcd_nibble_interface_test: clean");
    end else begin
      $display("char_lcd_nibble_interface_test: errors");
    end
    $finish;
  end

endmodule
